// ===== hw/rtl/fot_pkg.sv =====
`timescale 1ns / 1ps
package fot_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int TERM_FRAC_BITS_DEF = 14;
  localparam int LABEL_W = 24;
  localparam int NORM_W = 30;
  localparam int CORDIC_STEPS = 23;
  localparam int ANG_W = 25;
  localparam int ISQRT_STEPS = 31;
  localparam int ISQRT_PER_STG = 4;
  localparam logic [ANG_W-1:0] DEG90 = ANG_W'(90 * 65536);
  localparam logic [ANG_W+1:0] DEG180 = (ANG_W+2)'(180 * 65536);
  localparam logic [ANG_W+1:0] DEG360 = (ANG_W+2)'(360 * 65536);
  localparam logic [15:0] AZ_WRAP = 16'd46080;

  typedef struct packed {
    logic [23:0] fiber_label;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic signed [23:0] start_z;
    logic signed [23:0] end_x;
    logic signed [23:0] end_y;
    logic signed [23:0] end_z;
  } in_word_t;

  typedef struct packed {
    logic [23:0] label_out;
    logic [14:0] term_xx;
    logic [14:0] term_yy;
    logic [14:0] term_zz;
    logic signed [15:0] term_xy;
    logic [14:0] term_xz;
    logic signed [15:0] term_yz;
    logic [15:0] azimuth;
    logic [13:0] polar;
    logic signed [23:0] mid_x;
    logic signed [23:0] mid_y;
    logic signed [23:0] mid_z;
  } out_word_t;

  function automatic logic [ANG_W-1:0] atan_lut(input int i);
    logic [ANG_W-1:0] t;
    case (i)
      0: t = 25'd2949120;  1: t = 25'd1740967;  2: t = 25'd919879;
      3: t = 25'd466945;   4: t = 25'd234379;   5: t = 25'd117304;
      6: t = 25'd58666;    7: t = 25'd29335;    8: t = 25'd14668;
      9: t = 25'd7334;     10: t = 25'd3667;    11: t = 25'd1833;
      12: t = 25'd917;     13: t = 25'd458;     14: t = 25'd229;
      15: t = 25'd115;     16: t = 25'd57;      17: t = 25'd29;
      18: t = 25'd14;      19: t = 25'd7;       20: t = 25'd4;
      21: t = 25'd2;       22: t = 25'd1;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage

// ===== hw/rtl/fot_cordic.sv =====
`timescale 1ns / 1ps
module fot_cordic (
  input  logic clk,
  input  logic en,
  input  logic [fot_pkg::NORM_W+1:0] x_in,
  input  logic [fot_pkg::NORM_W+1:0] y_in,
  output logic [fot_pkg::ANG_W-1:0] ang_out
);
  import fot_pkg::*;
  localparam int W = NORM_W + 4;
  localparam int N = CORDIC_STEPS;

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [ANG_W+1:0] z_r [0:N];
  logic [1:0] sp_r [0:N];
  logic [ANG_W-1:0] ang_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= W'(x_in);
      y_r[0] <= W'(y_in);
      z_r[0] <= '0;
      sp_r[0] <= {y_in == '0, x_in == '0};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic signed [W-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [ANG_W+1:0] z_nxt;
    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + $signed({2'b0, atan_lut(i)});
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - $signed({2'b0, atan_lut(i)});
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= x_nxt;
        y_r[i+1] <= y_nxt;
        z_r[i+1] <= z_nxt;
        sp_r[i+1] <= sp_r[i];
      end
    end
  end

  always_comb begin
    if (sp_r[N][1]) begin
      ang_nxt = '0;
    end else if (sp_r[N][0]) begin
      ang_nxt = DEG90;
    end else if (z_r[N] < 0) begin
      ang_nxt = '0;
    end else if (z_r[N] > $signed({2'b0, DEG90})) begin
      ang_nxt = DEG90;
    end else begin
      ang_nxt = z_r[N][ANG_W-1:0];
    end
  end
  assign ang_out = ang_nxt;
endmodule

// ===== hw/rtl/fot_ratio.sv =====
`timescale 1ns / 1ps
module fot_ratio #(
  parameter int TERM_FRAC_BITS = fot_pkg::TERM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [2*fot_pkg::NORM_W-1:0] num_in,
  input  logic [2*fot_pkg::NORM_W+1:0] den_in,
  output logic [TERM_FRAC_BITS+1:0] q_out
);
  import fot_pkg::*;
  localparam int DW = 2 * NORM_W + 2;
  localparam int N = TERM_FRAC_BITS + 2;
  localparam int QW = TERM_FRAC_BITS + 2;

  logic [DW:0] rem_r [0:N];
  logic [DW-1:0] den_r [0:N];
  logic [QW-1:0] q_r [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= (DW+1)'(num_in);
      den_r[0] <= den_in;
      q_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stg
    logic [DW:0] sh, rem_nxt;
    logic bit_nxt;
    always_comb begin
      sh = (i == 0) ? rem_r[i] : {rem_r[i][DW-1:0], 1'b0};
      bit_nxt = (sh >= {1'b0, den_r[i]});
      rem_nxt = bit_nxt ? (sh - {1'b0, den_r[i]}) : sh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= rem_nxt;
        den_r[i+1] <= den_r[i];
        q_r[i+1] <= {q_r[i][QW-2:0], bit_nxt};
      end
    end
  end

  assign q_out = q_r[N];
endmodule

// ===== hw/rtl/fiber_orientation_tensor_core.sv =====
// Fiber orientation tensor core: one fiber (label and two endpoints) per cycle in,
// one result word per fiber out, in order. The longest path from input accept to output
// accept at the default settings runs through four front-end stages (difference and
// fold to dz >= 0, normalize, products, sums), one input register plus 8 stages of
// pipelined square root of dx^2+dy^2, one input register plus 23 stages of CORDIC for
// the polar angle, then the output register. The tensor-term dividers (TERM_FRAC_BITS+3
// stages) and the azimuth CORDIC (24 stages) run alongside and are delayed to match.
// Sustained rate is one fiber per cycle; backpressure stalls the whole pipeline, and a
// stalled stage holds its word.
`timescale 1ns / 1ps
module fiber_orientation_tensor_core #(
  parameter int COORD_BITS = fot_pkg::COORD_BITS_DEF,
  parameter int TERM_FRAC_BITS = fot_pkg::TERM_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  fot_pkg::in_word_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output fot_pkg::out_word_t out_data
);
  import fot_pkg::*;
  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int MW = 2 * NORM_W;
  localparam int SHW = $clog2(NORM_W + 1);
  localparam int SQ_STG = (ISQRT_STEPS + ISQRT_PER_STG - 1) / ISQRT_PER_STG;
  localparam int RT_LAT = TERM_FRAC_BITS + 3;
  localparam int CO_LAT = CORDIC_STEPS + 1;
  localparam int POL_LAT = 1 + SQ_STG + CO_LAT;
  localparam int LAT = 4 + POL_LAT + 1;
  localparam int QW = TERM_FRAC_BITS + 2;

  logic en;
  logic [LAT-1:0] vld_r;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: differences, fold, midpoint
  logic signed [DW-1:0] dx1, dy1, dz1;
  logic [DW-1:0] ax1_nxt, ay1_nxt, az1_nxt;
  logic [DW-1:0] ax1_r, ay1_r, az1_r;
  logic nx1_r, ny1_r;
  logic signed [CW-1:0] mx1_r, my1_r, mz1_r;
  logic [LABEL_W-1:0] lab1_r;
  logic signed [DW-1:0] sx, sy, sz;
  always_comb begin
    dx1 = DW'(in_data.start_x) - DW'(in_data.end_x);
    dy1 = DW'(in_data.start_y) - DW'(in_data.end_y);
    dz1 = DW'(in_data.start_z) - DW'(in_data.end_z);
    if (dz1 < 0) begin
      dx1 = -dx1;
      dy1 = -dy1;
      dz1 = -dz1;
    end
    ax1_nxt = dx1[DW-1] ? DW'(-dx1) : DW'(dx1);
    ay1_nxt = dy1[DW-1] ? DW'(-dy1) : DW'(dy1);
    az1_nxt = DW'(dz1);
    sx = DW'(in_data.start_x) + DW'(in_data.end_x);
    sy = DW'(in_data.start_y) + DW'(in_data.end_y);
    sz = DW'(in_data.start_z) + DW'(in_data.end_z);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= ax1_nxt;
      ay1_r <= ay1_nxt;
      az1_r <= az1_nxt;
      nx1_r <= dx1[DW-1];
      ny1_r <= dy1[DW-1];
      mx1_r <= sx[DW-1:1];
      my1_r <= sy[DW-1:1];
      mz1_r <= sz[DW-1:1];
      lab1_r <= in_data.fiber_label;
    end
  end

  // stage 2: normalize to [2^29, 2^30)
  logic [DW-1:0] m2;
  logic [NORM_W-1:0] ax2_r, ay2_r, az2_r;
  logic [NORM_W-1:0] ax2_nxt, ay2_nxt, az2_nxt;
  logic zero2_nxt, zero2_r, nx2_r, ny2_r;
  logic signed [CW-1:0] mx2_r, my2_r, mz2_r;
  logic [LABEL_W-1:0] lab2_r;
  logic [SHW-1:0] lz;
  logic [DW+NORM_W-1:0] wx, wy, wz;
  always_comb begin
    m2 = ax1_r | ay1_r | az1_r;
    lz = '0;
    for (int b = 0; b < DW; b++) begin
      if (m2[b]) lz = SHW'(b);
    end
    wx = {ax1_r, {NORM_W{1'b0}}} >> (lz + 1);
    wy = {ay1_r, {NORM_W{1'b0}}} >> (lz + 1);
    wz = {az1_r, {NORM_W{1'b0}}} >> (lz + 1);
    ax2_nxt = wx[NORM_W-1:0];
    ay2_nxt = wy[NORM_W-1:0];
    az2_nxt = wz[NORM_W-1:0];
    zero2_nxt = (m2 == '0);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r <= ax2_nxt;
      ay2_r <= ay2_nxt;
      az2_r <= az2_nxt;
      zero2_r <= zero2_nxt;
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
      mx2_r <= mx1_r;
      my2_r <= my1_r;
      mz2_r <= mz1_r;
      lab2_r <= lab1_r;
    end
  end

  // stage 3: products
  logic [MW-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;
  logic [NORM_W-1:0] ax3_r, ay3_r, az3_r;
  logic zero3_r, nx3_r, ny3_r;
  logic signed [CW-1:0] mx3_r, my3_r, mz3_r;
  logic [LABEL_W-1:0] lab3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= MW'(ax2_r) * MW'(ax2_r);
      pyy_r <= MW'(ay2_r) * MW'(ay2_r);
      pzz_r <= MW'(az2_r) * MW'(az2_r);
      pxy_r <= MW'(ax2_r) * MW'(ay2_r);
      pxz_r <= MW'(ax2_r) * MW'(az2_r);
      pyz_r <= MW'(ay2_r) * MW'(az2_r);
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      az3_r <= az2_r;
      zero3_r <= zero2_r;
      nx3_r <= nx2_r;
      ny3_r <= ny2_r;
      mx3_r <= mx2_r;
      my3_r <= my2_r;
      mz3_r <= mz2_r;
      lab3_r <= lab2_r;
    end
  end

  // stage 4: sums
  logic [MW+1:0] r2_r;
  logic [MW:0] rxy2_r;
  logic [MW-1:0] pxx4_r, pyy4_r, pzz4_r, pxy4_r, pxz4_r, pyz4_r;
  logic [NORM_W-1:0] ax4_r, ay4_r, az4_r;
  logic zero4_r, nx4_r, ny4_r;
  logic signed [CW-1:0] mx4_r, my4_r, mz4_r;
  logic [LABEL_W-1:0] lab4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= (MW+2)'(pxx_r) + (MW+2)'(pyy_r) + (MW+2)'(pzz_r);
      rxy2_r <= (MW+1)'(pxx_r) + (MW+1)'(pyy_r);
      pxx4_r <= pxx_r;
      pyy4_r <= pyy_r;
      pzz4_r <= pzz_r;
      pxy4_r <= pxy_r;
      pxz4_r <= pxz_r;
      pyz4_r <= pyz_r;
      ax4_r <= ax3_r;
      ay4_r <= ay3_r;
      az4_r <= az3_r;
      zero4_r <= zero3_r;
      nx4_r <= nx3_r;
      ny4_r <= ny3_r;
      mx4_r <= mx3_r;
      my4_r <= my3_r;
      mz4_r <= mz3_r;
      lab4_r <= lab3_r;
    end
  end

  // tensor terms
  logic [QW-1:0] q_w [0:5];
  logic [MW-1:0] nums [0:5];
  assign nums[0] = pxx4_r;
  assign nums[1] = pyy4_r;
  assign nums[2] = pzz4_r;
  assign nums[3] = pxy4_r;
  assign nums[4] = pxz4_r;
  assign nums[5] = pyz4_r;
  for (genvar k = 0; k < 6; k++) begin : g_div
    fot_ratio #(.TERM_FRAC_BITS(TERM_FRAC_BITS)) u_div (
      .clk(clk), .en(en), .num_in(nums[k]), .den_in(r2_r), .q_out(q_w[k])
    );
  end

  // azimuth cordic
  logic [ANG_W-1:0] az_ang;
  fot_cordic u_azc (
    .clk(clk), .en(en),
    .x_in((NORM_W+2)'(ax4_r)), .y_in((NORM_W+2)'(ay4_r)), .ang_out(az_ang)
  );

  // isqrt of rxy2, up to 4 steps per stage (3 in the last stage)
  localparam int SQW = MW + 2;
  logic [SQW-1:0] sv_r [0:SQ_STG];
  logic [SQW-1:0] sr_r [0:SQ_STG];
  logic [NORM_W-1:0] saz_r [0:SQ_STG];
  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0] <= SQW'(rxy2_r);
      sr_r[0] <= '0;
      saz_r[0] <= az4_r;
    end
  end
  for (genvar s = 0; s < SQ_STG; s++) begin : g_sq
    logic [SQW-1:0] v_c, r_c, bt;
    always_comb begin
      v_c = sv_r[s];
      r_c = sr_r[s];
      for (int j = 0; j < ISQRT_PER_STG; j++) begin
        if (s * ISQRT_PER_STG + j < ISQRT_STEPS) begin
          bt = SQW'(1) << (2 * (ISQRT_STEPS - 1 - s * ISQRT_PER_STG - j));
          if (v_c >= r_c + bt) begin
            v_c = v_c - (r_c + bt);
            r_c = (r_c >> 1) + bt;
          end else begin
            r_c = r_c >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[s+1] <= v_c;
        sr_r[s+1] <= r_c;
        saz_r[s+1] <= saz_r[s];
      end
    end
  end

  logic [ANG_W-1:0] pol_ang;
  fot_cordic u_polc (
    .clk(clk), .en(en),
    .x_in((NORM_W+2)'(saz_r[SQ_STG])), .y_in((NORM_W+2)'(sr_r[SQ_STG])),
    .ang_out(pol_ang)
  );

  // side delay lines to line up with the polar result
  localparam int SW = 3 + 3 * CW + LABEL_W;
  logic [SW-1:0] sd_r [0:POL_LAT-1];
  logic [QW-1:0] qd_r [0:5][0:POL_LAT-RT_LAT-1];
  logic [ANG_W-1:0] ad_r [0:POL_LAT-CO_LAT-1];
  logic xy0;
  assign xy0 = (ax4_r == '0) && (ay4_r == '0);
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= {zero4_r || xy0, nx4_r, ny4_r, mx4_r, my4_r, mz4_r, lab4_r};
      for (int i = 1; i < POL_LAT; i++) sd_r[i] <= sd_r[i-1];
      for (int k = 0; k < 6; k++) begin
        qd_r[k][0] <= q_w[k];
        for (int i = 1; i < POL_LAT - RT_LAT; i++) qd_r[k][i] <= qd_r[k][i-1];
      end
      ad_r[0] <= az_ang;
      for (int i = 1; i < POL_LAT - CO_LAT; i++) ad_r[i] <= ad_r[i-1];
    end
  end

  // zero-length fibers: r2 = 0 gives q = all ones in the divider; mask here
  logic zr_r [0:POL_LAT-1];
  always_ff @(posedge clk) begin
    if (en) begin
      zr_r[0] <= zero4_r;
      for (int i = 1; i < POL_LAT; i++) zr_r[i] <= zr_r[i-1];
    end
  end

  // final stage
  logic [SW-1:0] sf;
  logic nang, nxf, nyf;
  logic [QW-1:0] tq [0:5];
  logic [15:0] tm [0:5];
  logic [ANG_W+1:0] full;
  logic [ANG_W+1:0] ar;
  logic [15:0] azi;
  logic [ANG_W+1:0] pr;
  out_word_t ow_nxt;
  out_word_t out_r;
  always_comb begin
    sf = sd_r[POL_LAT-1];
    nang = sf[SW-1];
    nxf = sf[SW-2];
    nyf = sf[SW-3];
    for (int k = 0; k < 6; k++) begin
      tq[k] = qd_r[k][POL_LAT-RT_LAT-1];
      tm[k] = 16'((17'(tq[k]) + 17'd1) >> 1);
    end
    if (!nxf && !nyf) full = (ANG_W+2)'(ad_r[POL_LAT-CO_LAT-1]);
    else if (nxf && !nyf) full = DEG180 - (ANG_W+2)'(ad_r[POL_LAT-CO_LAT-1]);
    else if (nxf && nyf) full = DEG180 + (ANG_W+2)'(ad_r[POL_LAT-CO_LAT-1]);
    else full = DEG360 - (ANG_W+2)'(ad_r[POL_LAT-CO_LAT-1]);
    ar = (full + (ANG_W+2)'(256)) >> 9;
    azi = ar[15:0];
    if (azi >= AZ_WRAP) azi = azi - AZ_WRAP;
    pr = ((ANG_W+2)'(pol_ang) + (ANG_W+2)'(256)) >> 9;
    ow_nxt.label_out = sf[LABEL_W-1:0];
    ow_nxt.mid_z = sf[LABEL_W +: CW];
    ow_nxt.mid_y = sf[LABEL_W+CW +: CW];
    ow_nxt.mid_x = sf[LABEL_W+2*CW +: CW];
    ow_nxt.term_xx = tm[0][14:0];
    ow_nxt.term_yy = tm[1][14:0];
    ow_nxt.term_zz = tm[2][14:0];
    ow_nxt.term_xy = nyf ? -tm[3] : tm[3];
    ow_nxt.term_xz = tm[4][14:0];
    ow_nxt.term_yz = nyf ? -tm[5] : tm[5];
    ow_nxt.azimuth = nang ? '0 : azi;
    ow_nxt.polar = nang ? '0 : pr[13:0];
    if (zr_r[POL_LAT-1]) begin
      ow_nxt.term_xx = '0;
      ow_nxt.term_yy = '0;
      ow_nxt.term_zz = '0;
      ow_nxt.term_xy = '0;
      ow_nxt.term_xz = '0;
      ow_nxt.term_yz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= ow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data = out_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_azr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.azimuth < AZ_WRAP)
    else $error("azimuth out of range");
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted word lost");
endmodule

// ===== dv/fot_checker.sv =====
`timescale 1ns / 1ps
module fot_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  fot_pkg::in_word_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  fot_pkg::out_word_t out_data,
  output int   fail_count,
  output int   pending
);
  import fot_pkg::*;

  localparam int FRAC = 14;
  localparam longint ANG_DEG = 65536;

  out_word_t want_q[$];

  initial fail_count = 0;
  assign pending = want_q.size();

  function automatic longint atan_entry(input int i);
    longint t [0:22] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                         29, 14, 7, 4, 2, 1};
    return t[i];
  endfunction

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned term_ratio(input longint unsigned num,
                                                 input longint unsigned den);
    longint unsigned q, rem;
    q = 0;
    rem = num;
    if (rem >= den) begin
      q = 1;
      rem = rem - den;
    end
    for (int i = 0; i <= FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 1;
      end
    end
    return (q + 1) >> 1;
  endfunction

  function automatic longint cordic_angle(input longint x, input longint y);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return 0;
    if (x == 0) return 90 * ANG_DEG;
    for (int i = 0; i < 23; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_entry(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_entry(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * ANG_DEG) z = 90 * ANG_DEG;
    return z;
  endfunction

  function automatic out_word_t predict_fiber(input in_word_t w);
    out_word_t r;
    longint x1, y1, z1, x2, y2, z2, dx, dy, dz, a, full;
    longint unsigned ax, ay, az, m, r2, azim, pol, rxy, mag;
    bit negx, negy;
    x1 = w.start_x; y1 = w.start_y; z1 = w.start_z;
    x2 = w.end_x;   y2 = w.end_y;   z2 = w.end_z;
    dx = x1 - x2; dy = y1 - y2; dz = z1 - z2;
    r = '0;
    azim = 0;
    pol = 0;
    if (dz < 0) begin
      dx = -dx; dy = -dy; dz = -dz;
    end
    negx = dx < 0;
    negy = dy < 0;
    ax = negx ? -dx : dx;
    ay = negy ? -dy : dy;
    az = dz;
    m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    if (m != 0) begin
      while (m < (64'd1 << 29)) begin
        m = m << 1; ax = ax << 1; ay = ay << 1; az = az << 1;
      end
      r2 = ax * ax + ay * ay + az * az;
      r.term_xx = term_ratio(ax * ax, r2);
      r.term_yy = term_ratio(ay * ay, r2);
      r.term_zz = term_ratio(az * az, r2);
      mag = term_ratio(ax * ay, r2);
      r.term_xy = negy ? -mag : mag;
      r.term_xz = term_ratio(ax * az, r2);
      mag = term_ratio(ay * az, r2);
      r.term_yz = negy ? -mag : mag;
      if (ax != 0 || ay != 0) begin
        a = cordic_angle(ax, ay);
        rxy = root_floor(ax * ax + ay * ay);
        if (!negx && !negy) full = a;
        else if (negx && !negy) full = 180 * ANG_DEG - a;
        else if (negx && negy) full = 180 * ANG_DEG + a;
        else full = 360 * ANG_DEG - a;
        azim = (full + 256) >> 9;
        if (azim >= 46080) azim = azim - 46080;
        pol = (cordic_angle(az, rxy) + 256) >> 9;
      end
    end
    r.label_out = w.fiber_label;
    r.azimuth = azim;
    r.polar = pol;
    r.mid_x = (x1 + x2) >>> 1;
    r.mid_y = (y1 + y2) >>> 1;
    r.mid_z = (z1 + z2) >>> 1;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if (in_valid && in_ready) want_q.push_back(predict_fiber(in_data));
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          e = want_q.pop_front();
          if (out_data.label_out != e.label_out)
            report_mismatch("label", out_data.label_out, e.label_out);
          if (out_data.term_xx != e.term_xx)
            report_mismatch("term_xx", out_data.term_xx, e.term_xx);
          if (out_data.term_yy != e.term_yy)
            report_mismatch("term_yy", out_data.term_yy, e.term_yy);
          if (out_data.term_zz != e.term_zz)
            report_mismatch("term_zz", out_data.term_zz, e.term_zz);
          if (out_data.term_xy != e.term_xy)
            report_mismatch("term_xy", out_data.term_xy, e.term_xy);
          if (out_data.term_xz != e.term_xz)
            report_mismatch("term_xz", out_data.term_xz, e.term_xz);
          if (out_data.term_yz != e.term_yz)
            report_mismatch("term_yz", out_data.term_yz, e.term_yz);
          if (out_data.azimuth != e.azimuth)
            report_mismatch("azimuth", out_data.azimuth, e.azimuth);
          if (out_data.polar != e.polar)
            report_mismatch("polar", out_data.polar, e.polar);
          if (out_data.mid_x != e.mid_x) report_mismatch("mid_x", out_data.mid_x, e.mid_x);
          if (out_data.mid_y != e.mid_y) report_mismatch("mid_y", out_data.mid_y, e.mid_y);
          if (out_data.mid_z != e.mid_z) report_mismatch("mid_z", out_data.mid_z, e.mid_z);
        end
      end
    end
  end
endmodule

// ===== dv/tb_fiber_orientation_tensor_core.sv =====
`timescale 1ns / 1ps
module tb_fiber_orientation_tensor_core;
  import fot_pkg::*;

  localparam int RANDOM_FIBERS = 1800;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CMIN = -24'sh800000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  int fail_count;
  int pending;
  int sent = 0;
  int idle_cycles = 0;
  bit stall_done = 1'b0;

  always #5 clk = ~clk;

  fiber_orientation_tensor_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  fot_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 50) return 0;
    if ($urandom_range(0, 99) < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'($signed(24'($urandom_range(0, 15))) - 24'sd8);
      2: return $urandom_range(0, 1) ? CMAX : CMIN;
      default: return 24'($signed(24'($urandom_range(0, 4095))) - 24'sd2048);
    endcase
  endfunction

  task automatic send_fiber(input in_word_t w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic in_word_t fiber_of(input logic [23:0] lab,
      input logic signed [23:0] sx, sy, sz, ex, ey, ez);
    in_word_t w;
    w.fiber_label = lab;
    w.start_x = sx; w.start_y = sy; w.start_z = sz;
    w.end_x = ex; w.end_y = ey; w.end_z = ez;
    return w;
  endfunction

  task automatic send_random();
    in_word_t w;
    logic signed [23:0] c;
    w.fiber_label = 24'($urandom);
    w.start_x = rand_coord(); w.start_y = rand_coord(); w.start_z = rand_coord();
    w.end_x = rand_coord(); w.end_y = rand_coord(); w.end_z = rand_coord();
    case ($urandom_range(0, 9))
      0: begin w.end_x = w.start_x; w.end_y = w.start_y; end
      1: begin w.end_x = w.start_x; w.end_y = w.start_y; w.end_z = w.start_z; end
      2: w.end_z = w.start_z;
      3: begin c = $signed(24'($urandom_range(0, 1000))); w.end_y = w.start_y + c; end
      default: ;
    endcase
    send_fiber(w);
  endtask

  // receiver: random stalls, one long hold-off during the random phase
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      if (!stall_done && sent > 400) begin
        stall_done = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_fiber(fiber_of(24'h000000, 0, 0, 0, 0, 0, 0));
    send_fiber(fiber_of(24'hFFFFFF, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    send_fiber(fiber_of(24'hA5A5A5, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_fiber(fiber_of(24'h5A5A5A, 0, 0, 5, 0, 0, -3));
    send_fiber(fiber_of(24'h000001, 7, 9, -100, 7, 9, 100));
    send_fiber(fiber_of(24'h000002, 100, 0, 0, 0, 0, 0));
    send_fiber(fiber_of(24'h000003, 0, 100, 0, 0, 0, 0));
    send_fiber(fiber_of(24'h000004, -100, 0, 0, 0, 0, 0));
    send_fiber(fiber_of(24'h000005, 0, -100, 0, 0, 0, 0));
    send_fiber(fiber_of(24'h000006, 1, 1, 1, 0, 0, 0));
    send_fiber(fiber_of(24'h000007, -1, 1, 1, 0, 0, 0));
    send_fiber(fiber_of(24'h000008, -1, -1, 1, 0, 0, 0));
    send_fiber(fiber_of(24'h000009, 1, -1, 1, 0, 0, 0));
    send_fiber(fiber_of(24'h00000A, 1, 2, -3, 0, 0, 0));
    send_fiber(fiber_of(24'h00000B, 3, 0, 4, 0, 0, 0));
    send_fiber(fiber_of(24'h00000C, -1, -3, -5, 0, 1, 0));
    send_fiber(fiber_of(24'h00000D, CMAX, 0, 0, CMIN, 0, 0));
    send_fiber(fiber_of(24'h00000E, 0, CMIN, 1, 0, CMAX, 0));
    send_fiber(fiber_of(24'h00000F, 1, 0, 0, 0, 1, 0));
    // sender pause until the pipe is empty
    wait_drained();
    for (int i = 0; i < RANDOM_FIBERS; i++) begin
      if (i == 900) wait_drained();
      send_random();
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d fibers: axis-aligned, coincident, extreme and random endpoints", sent);
    $display("with random stalls on both sides and one long output hold-off");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/fot_pkg.sv
hw/rtl/fot_cordic.sv
hw/rtl/fot_ratio.sv
hw/rtl/fiber_orientation_tensor_core.sv
dv/fot_checker.sv
dv/tb_fiber_orientation_tensor_core.sv
